@@ src/smcatr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Smart card ATR parser package
// Shared types, codes and constants for the answer-to-reset byte parser.
// ----------------------------------------------------------------------------
package smcatr_pkg;

    localparam int MAX_ATR_BYTES_DEF = 33;

    localparam logic [7:0] TS_DIRECT    = 8'h3B;
    localparam logic [7:0] TS_INVERSE   = 8'h3F;
    localparam logic [7:0] RATE_DEFAULT = 8'h11;
    localparam logic [8:0] GUARD_BASE   = 9'd12;
    localparam logic [3:0] PROTO_T1     = 4'h1;
    localparam logic [3:0] PROTO_T15    = 4'hF;
    localparam logic [3:0] GROUP_MAX    = 4'hF;
    localparam logic [5:0] COUNT_MAX    = 6'd63;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Interface byte kinds within one group.
    localparam logic [1:0] FIELD_TA = 2'd0;
    localparam logic [1:0] FIELD_TB = 2'd1;
    localparam logic [1:0] FIELD_TC = 2'd2;
    localparam logic [1:0] FIELD_TD = 2'd3;

    typedef enum logic [5:0] {
        STG_WAIT_TS = 6'b000001,
        STG_FORMAT  = 6'b000010,
        STG_IFACE   = 6'b000100,
        STG_HIST    = 6'b001000,
        STG_TCK     = 6'b010000,
        STG_DONE    = 6'b100000
    } stage_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       stored;
        logic [7:0] stored_byte;
        logic [5:0] byte_position;
        logic       atr_done;
        logic [5:0] atr_length;
        logic [7:0] rate_code;
        logic       specific_mode;
        logic [8:0] guard_time;
        logic       prefer_t1;
        logic [7:0] frame_size;
        logic [7:0] edc_byte;
    } rsp_t;

    typedef struct packed {
        stage_t     stage;
        logic [3:0] presence;
        logic [1:0] next_field;
        logic [3:0] group_index;
        logic [3:0] hist_left;
        logic       tck_expected;
        logic [5:0] byte_count;
        logic [7:0] rate_code;
        logic       specific;
        logic [8:0] guard;
        logic       t1;
        logic [7:0] frame_size;
        logic [7:0] edc;
    } parse_state_t;

    function automatic parse_state_t smcatr_reset_state(input logic init_t1);
        parse_state_t s;
        s.stage        = STG_WAIT_TS;
        s.presence     = 4'd0;
        s.next_field   = FIELD_TA;
        s.group_index  = 4'd0;
        s.hist_left    = 4'd0;
        s.tck_expected = 1'b0;
        s.byte_count   = 6'd0;
        s.rate_code    = RATE_DEFAULT;
        s.specific     = 1'b0;
        s.guard        = GUARD_BASE;
        s.t1           = init_t1;
        s.frame_size   = 8'd0;
        s.edc          = 8'd0;
        return s;
    endfunction

endpackage
`default_nettype wire

@@ src/smcatr_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ATR parser step logic
// Next parser state and the result for one transfer, purely combinational.
// ----------------------------------------------------------------------------
module smcatr_step #(
    parameter int MAX_ATR_BYTES = smcatr_pkg::MAX_ATR_BYTES_DEF
) (
    input  wire smcatr_pkg::parse_state_t cur,
    input  wire smcatr_pkg::req_t         req,
    input  wire                           init_t1,
    output smcatr_pkg::parse_state_t      nxt,
    output smcatr_pkg::rsp_t              rsp
);
    import smcatr_pkg::*;

    localparam logic [5:0] LEN_LIMIT = 6'((MAX_ATR_BYTES > 63) ? 63 : MAX_ATR_BYTES);

    logic [3:0] masked;
    logic [1:0] field;
    logic       found;

    // Lowest present field at or after the expected one.
    always_comb
    begin
        masked = cur.presence & (4'hF << cur.next_field);
        field  = FIELD_TA;
        found  = 1'b0;
        for (int i = 3; i >= 0; i--)
        begin
            if (masked[i])
            begin
                found = 1'b1;
                field = 2'(i);
            end
        end
    end

    always_comb
    begin
        logic       store;
        logic       done;
        logic [5:0] pos;
        logic       end_iface;
        logic       end_hist;
        logic [7:0] b;

        b         = req.rx_byte;
        nxt       = cur;
        store     = 1'b0;
        done      = 1'b0;
        pos       = 6'd0;
        end_iface = 1'b0;
        end_hist  = 1'b0;

        if (req.req_type == REQ_RESTART)
        begin
            nxt = smcatr_reset_state(init_t1);
        end
        else
        begin
            case (cur.stage)
                STG_WAIT_TS:
                begin
                    if (b == TS_DIRECT || b == TS_INVERSE)
                    begin
                        store     = 1'b1;
                        nxt.stage = STG_FORMAT;
                    end
                end
                STG_FORMAT:
                begin
                    store           = 1'b1;
                    nxt.presence    = b[7:4];
                    nxt.hist_left   = b[3:0];
                    nxt.next_field  = FIELD_TA;
                    nxt.group_index = 4'd0;
                    if (b[7:4] == 4'd0)
                        end_iface = 1'b1;
                    else
                        nxt.stage = STG_IFACE;
                end
                STG_IFACE:
                begin
                    store = 1'b1;
                    if (!found)
                    begin
                        end_iface = 1'b1;
                    end
                    else if (field == FIELD_TD)
                    begin
                        if (cur.group_index == 4'd0 && b[3:0] == PROTO_T1)
                            nxt.t1 = 1'b1;
                        if (b[3:0] == PROTO_T15)
                            nxt.tck_expected = 1'b1;
                        if (cur.group_index != GROUP_MAX)
                            nxt.group_index = cur.group_index + 4'd1;
                        nxt.presence   = b[7:4];
                        nxt.next_field = FIELD_TA;
                        if (b[7:4] == 4'd0)
                            end_iface = 1'b1;
                    end
                    else
                    begin
                        if (field == FIELD_TA)
                        begin
                            if (cur.group_index == 4'd0)
                                nxt.rate_code = b;
                            if (cur.group_index == 4'd1)
                                nxt.specific = 1'b1;
                            if (cur.t1)
                                nxt.frame_size = b;
                        end
                        else if (field == FIELD_TC)
                        begin
                            if (cur.group_index == 4'd0)
                                nxt.guard = GUARD_BASE + {1'b0, b};
                            if (cur.t1)
                                nxt.edc = b;
                        end
                        nxt.next_field = field + 2'd1;
                        // Keep only the fields that still follow in this group.
                        nxt.presence = cur.presence & (4'b1110 << field);
                        if ((cur.presence & (4'b1110 << field)) == 4'd0)
                            end_iface = 1'b1;
                    end
                end
                STG_HIST:
                begin
                    store = 1'b1;
                    if (cur.hist_left != 4'd0)
                        nxt.hist_left = cur.hist_left - 4'd1;
                    if (cur.hist_left <= 4'd1)
                        end_hist = 1'b1;
                end
                STG_TCK:
                begin
                    store     = 1'b1;
                    nxt.stage = STG_DONE;
                    done      = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (end_iface)
            begin
                if (nxt.hist_left != 4'd0)
                    nxt.stage = STG_HIST;
                else if (nxt.tck_expected)
                    nxt.stage = STG_TCK;
                else
                begin
                    nxt.stage = STG_DONE;
                    done      = 1'b1;
                end
            end

            if (end_hist)
            begin
                if (nxt.tck_expected)
                    nxt.stage = STG_TCK;
                else
                begin
                    nxt.stage = STG_DONE;
                    done      = 1'b1;
                end
            end

            if (store)
            begin
                pos = cur.byte_count;
                if (cur.byte_count < COUNT_MAX)
                    nxt.byte_count = cur.byte_count + 6'd1;
                // A runaway ATR is cut off at the length limit.
                if (!done && nxt.byte_count >= LEN_LIMIT)
                begin
                    nxt.stage = STG_DONE;
                    done      = 1'b1;
                end
            end
        end

        rsp.stored        = store;
        rsp.stored_byte   = store ? b : 8'd0;
        rsp.byte_position = pos;
        rsp.atr_done      = done;
        rsp.atr_length    = nxt.byte_count;
        rsp.rate_code     = nxt.rate_code;
        rsp.specific_mode = nxt.specific;
        rsp.guard_time    = nxt.guard;
        rsp.prefer_t1     = nxt.t1;
        rsp.frame_size    = nxt.frame_size;
        rsp.edc_byte      = nxt.edc;
    end

endmodule
`default_nettype wire

@@ src/smartcard_atr_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Smart card ATR parser
// Parses an answer-to-reset byte stream and captures the protocol settings.
// ----------------------------------------------------------------------------
//  channel   signals                      direction  content
//  req       req_valid/req_ready/req      in         restart or received byte
//  rsp       rsp_valid/rsp_ready/rsp      out        one result per request
//  cfg       cfg_wr_en/cfg_wr_data        in         initial protocol T=1
//
//  The parser state and the result register are both loaded at the edge that
//  completes the request transfer.
//  A new request is taken every cycle while the result register is empty or
//  its result is taken in the same cycle; a stalled result holds requests.
//  Reset loads the parser state and clears the configuration to T=0.
// ----------------------------------------------------------------------------
module smartcard_atr_parser_unit #(
    parameter int MAX_ATR_BYTES = smcatr_pkg::MAX_ATR_BYTES_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   req_valid,
    output logic                  req_ready,
    input  wire smcatr_pkg::req_t req,
    output logic                  rsp_valid,
    input  wire                   rsp_ready,
    output smcatr_pkg::rsp_t      rsp,
    input  wire                   cfg_wr_en,
    input  wire                   cfg_wr_data
);
    import smcatr_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    rsp_t         rsp_reg;
    rsp_t         rsp_next;
    logic         rsp_valid_reg;
    logic         init_t1_reg;
    logic         req_fire;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    smcatr_step #(
        .MAX_ATR_BYTES(MAX_ATR_BYTES)
    ) u_step (
        .cur    (state_reg),
        .req    (req),
        .init_t1(init_t1_reg),
        .nxt    (state_next),
        .rsp    (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smcatr_reset_state(1'b0);
            rsp_valid_reg <= 1'b0;
            init_t1_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                init_t1_reg <= cfg_wr_data;
            if (req_fire)
            begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

@@ sim/tb_smartcard_atr_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Smart card ATR parser testbench
// Streams answer-to-reset byte sequences into the parser: first a short
// directed set, then mostly well-formed ATRs with random content, plus cut-off
// sequences, very deep interface groups, over-long ATRs and plain noise. Every
// accepted request is run through an in-bench model of the parser, and every
// result transfer is compared field by field with the oldest prediction. The
// initial protocol register is rewritten between phases while the parser is
// idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_smartcard_atr_parser_unit;

    import smcatr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 250;
    localparam int NO_FIELD      = 4;
    localparam int ATR_LEN_LIMIT = (MAX_ATR_BYTES_DEF > 63) ? 63 : MAX_ATR_BYTES_DEF;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic req_valid   = 1'b0;
    logic req_ready;
    req_t req         = '0;
    logic rsp_valid;
    logic rsp_ready   = 1'b0;
    rsp_t rsp;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    req_t        pending_bytes[$];
    rsp_t        expected_atr_rsps[$];
    int          queued_count = 0;
    int          fail_count   = 0;
    int unsigned cycle_count  = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;

    // Parser model state.
    logic        cfg_t1_shadow = 1'b0;
    stage_t      atr_stage;
    logic [3:0]  atr_presence;
    logic [1:0]  atr_next_field;
    logic [3:0]  atr_group;
    logic [3:0]  atr_hist_left;
    logic        atr_tck_due;
    logic [5:0]  atr_count;
    logic [7:0]  atr_rate;
    logic        atr_specific;
    logic [8:0]  atr_guard;
    logic        atr_t1;
    logic [7:0]  atr_frame;
    logic [7:0]  atr_edc;

    smartcard_atr_parser_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void restart_atr_model();
        atr_stage      = STG_WAIT_TS;
        atr_presence   = 4'd0;
        atr_next_field = FIELD_TA;
        atr_group      = 4'd0;
        atr_hist_left  = 4'd0;
        atr_tck_due    = 1'b0;
        atr_count      = 6'd0;
        atr_rate       = RATE_DEFAULT;
        atr_specific   = 1'b0;
        atr_guard      = GUARD_BASE;
        atr_t1         = cfg_t1_shadow;
        atr_frame      = 8'd0;
        atr_edc        = 8'd0;
    endfunction

    // Picks the stage that follows the interface bytes; returns 1 when the ATR ends here.
    function automatic logic leave_interface_part();
        if (atr_hist_left != 4'd0) begin
            atr_stage = STG_HIST;
            return 1'b0;
        end
        if (atr_tck_due) begin
            atr_stage = STG_TCK;
            return 1'b0;
        end
        atr_stage = STG_DONE;
        return 1'b1;
    endfunction

    function automatic logic take_interface_byte(input logic [7:0] b);
        int f;
        int k;
        f = NO_FIELD;
        for (k = 3; k >= 0; k--)
            if (k >= atr_next_field && atr_presence[k])
                f = k;
        if (f == NO_FIELD)
            return leave_interface_part();
        if (f == FIELD_TD) begin
            if (atr_group == 4'd0 && b[3:0] == PROTO_T1)
                atr_t1 = 1'b1;
            if (b[3:0] == PROTO_T15)
                atr_tck_due = 1'b1;
            if (atr_group != GROUP_MAX)
                atr_group = atr_group + 4'd1;
            atr_presence   = b[7:4];
            atr_next_field = FIELD_TA;
            if (atr_presence == 4'd0)
                return leave_interface_part();
            return 1'b0;
        end
        if (f == FIELD_TA) begin
            if (atr_group == 4'd0)
                atr_rate = b;
            if (atr_group == 4'd1)
                atr_specific = 1'b1;
            if (atr_t1)
                atr_frame = b;
        end else if (f == FIELD_TC) begin
            if (atr_group == 4'd0)
                atr_guard = GUARD_BASE + {1'b0, b};
            if (atr_t1)
                atr_edc = b;
        end
        // Only fields after this one may still follow within the group.
        atr_next_field = f[1:0] + 2'd1;
        atr_presence   = atr_presence & (4'hF << (f + 1));
        if (atr_presence == 4'd0)
            return leave_interface_part();
        return 1'b0;
    endfunction

    function automatic rsp_t predict_atr_result(input req_t r);
        rsp_t       res;
        logic       keep;
        logic       done;
        logic [5:0] pos;
        keep = 1'b0;
        done = 1'b0;
        pos  = 6'd0;
        if (r.req_type == REQ_RESTART) begin
            restart_atr_model();
        end else begin
            case (atr_stage)
                STG_WAIT_TS: begin
                    if (r.rx_byte == TS_DIRECT || r.rx_byte == TS_INVERSE) begin
                        keep      = 1'b1;
                        atr_stage = STG_FORMAT;
                    end
                end
                STG_FORMAT: begin
                    keep           = 1'b1;
                    atr_presence   = r.rx_byte[7:4];
                    atr_hist_left  = r.rx_byte[3:0];
                    atr_next_field = FIELD_TA;
                    atr_group      = 4'd0;
                    if (atr_presence == 4'd0)
                        done = leave_interface_part();
                    else
                        atr_stage = STG_IFACE;
                end
                STG_IFACE: begin
                    keep = 1'b1;
                    done = take_interface_byte(r.rx_byte);
                end
                STG_HIST: begin
                    keep = 1'b1;
                    if (atr_hist_left != 4'd0)
                        atr_hist_left = atr_hist_left - 4'd1;
                    if (atr_hist_left == 4'd0) begin
                        if (atr_tck_due) begin
                            atr_stage = STG_TCK;
                        end else begin
                            atr_stage = STG_DONE;
                            done      = 1'b1;
                        end
                    end
                end
                STG_TCK: begin
                    keep      = 1'b1;
                    atr_stage = STG_DONE;
                    done      = 1'b1;
                end
                default: ;
            endcase
            if (keep) begin
                pos = atr_count;
                if (atr_count != COUNT_MAX)
                    atr_count = atr_count + 6'd1;
                if (!done && atr_count >= ATR_LEN_LIMIT) begin
                    atr_stage = STG_DONE;
                    done      = 1'b1;
                end
            end
        end
        res.stored        = keep;
        res.stored_byte   = keep ? r.rx_byte : 8'h00;
        res.byte_position = pos;
        res.atr_done      = done;
        res.atr_length    = atr_count;
        res.rate_code     = atr_rate;
        res.specific_mode = atr_specific;
        res.guard_time    = atr_guard;
        res.prefer_t1     = atr_t1;
        res.frame_size    = atr_frame;
        res.edc_byte      = atr_edc;
        return res;
    endfunction

    task automatic push_req(input logic kind, input logic [7:0] b);
        req_t r;
        r.req_type = kind;
        r.rx_byte  = b;
        pending_bytes.push_back(r);
        queued_count++;
    endtask

    // Queues one ATR: optional restart and leading junk, TS, T0, interface groups,
    // historical bytes and TCK when some TD names T=15. A broken ATR is cut short.
    task automatic queue_atr(input int n_groups, input bit td_only, input bit broken);
        logic [7:0] seq[$];
        logic [7:0] b;
        logic [3:0] mask;
        logic [3:0] next_mask;
        logic [3:0] proto;
        int         hist;
        int         g;
        int         keep;
        bit         tck;
        if ($urandom_range(0, 7) != 0)
            push_req(REQ_RESTART, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == TS_DIRECT || b == TS_INVERSE);
                push_req(REQ_BYTE, b);
            end
        end
        mask = td_only ? 4'h8 : 4'($urandom_range(0, 15));
        hist = td_only ? $urandom_range(0, 3) : $urandom_range(0, 15);
        if (n_groups == 0)
            mask[3] = 1'b0;
        seq.push_back($urandom_range(0, 1) ? TS_DIRECT : TS_INVERSE);
        seq.push_back({mask, hist[3:0]});
        tck = 1'b0;
        for (g = 0; g < 64; g++) begin
            if (mask[0])
                seq.push_back(8'($urandom_range(0, 255)));
            if (mask[1])
                seq.push_back(8'($urandom_range(0, 255)));
            if (mask[2])
                seq.push_back(8'($urandom_range(0, 255)));
            if (!mask[3])
                break;
            next_mask = td_only ? 4'h8 : 4'($urandom_range(0, 15));
            if (g + 1 >= n_groups)
                next_mask[3] = 1'b0;
            case ($urandom_range(0, 3))
                0:       proto = PROTO_T1;
                1:       proto = PROTO_T15;
                default: proto = 4'($urandom_range(0, 15));
            endcase
            if (proto == PROTO_T15)
                tck = 1'b1;
            seq.push_back({next_mask, proto});
            mask = next_mask;
        end
        repeat (hist)
            seq.push_back(8'($urandom_range(0, 255)));
        if (tck)
            seq.push_back(8'($urandom_range(0, 255)));
        keep = broken ? $urandom_range(1, seq.size()) : seq.size();
        for (g = 0; g < keep; g++)
            push_req(REQ_BYTE, seq[g]);
        // Bytes after a completed ATR must be ignored.
        if (!broken)
            repeat ($urandom_range(0, 2))
                push_req(REQ_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin : req_driver
        if (!rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
            restart_atr_model();
        end else begin
            if (req_valid && req_ready)
                expected_atr_rsps.push_back(predict_atr_result(req));
            if (!req_valid || req_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    req       <= pending_bytes.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; the stall pattern changes with bits 8:7 of the cycle counter.
    always @(posedge clk) begin : rsp_monitor
        rsp_t want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_atr_rsps.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    fail_count++;
                end else begin
                    want = expected_atr_rsps.pop_front();
                    compare_field("stored", 32'(want.stored), 32'(rsp.stored));
                    compare_field("stored_byte", 32'(want.stored_byte),
                                  32'(rsp.stored_byte));
                    compare_field("byte_position", 32'(want.byte_position),
                                  32'(rsp.byte_position));
                    compare_field("atr_done", 32'(want.atr_done), 32'(rsp.atr_done));
                    compare_field("atr_length", 32'(want.atr_length),
                                  32'(rsp.atr_length));
                    compare_field("rate_code", 32'(want.rate_code), 32'(rsp.rate_code));
                    compare_field("specific_mode", 32'(want.specific_mode),
                                  32'(rsp.specific_mode));
                    compare_field("guard_time", 32'(want.guard_time),
                                  32'(rsp.guard_time));
                    compare_field("prefer_t1", 32'(want.prefer_t1), 32'(rsp.prefer_t1));
                    compare_field("frame_size", 32'(want.frame_size),
                                  32'(rsp.frame_size));
                    compare_field("edc_byte", 32'(want.edc_byte), 32'(rsp.edc_byte));
                end
            end
            case (cycle_count[8:7])
                2'd0:    rsp_ready <= 1'b1;
                2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    rsp_ready <= (cycle_count % 3 == 0);
                default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int sel;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 4; phase++) begin
            // The new setting only shows after the next restart transfer.
            @(posedge clk);
            cfg_wr_en     <= 1'b1;
            cfg_wr_data   <= phase[0];
            cfg_t1_shadow = phase[0];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            if (phase == 0) begin
                push_req(REQ_RESTART, 8'hFF);
                push_req(REQ_BYTE, 8'h00);
                push_req(REQ_BYTE, 8'hFF);
                // TS then a T0 with no interface and no historical bytes.
                push_req(REQ_BYTE, TS_INVERSE);
                push_req(REQ_BYTE, 8'h00);
                push_req(REQ_BYTE, 8'hAA);
                push_req(REQ_RESTART, 8'h00);
                push_req(REQ_BYTE, TS_DIRECT);
                push_req(REQ_BYTE, 8'hF1);
                push_req(REQ_BYTE, 8'h96);
                push_req(REQ_BYTE, 8'h00);
                push_req(REQ_BYTE, 8'hFF);
                // TD1 selects T=1 and announces TA2 and TD2.
                push_req(REQ_BYTE, 8'h91);
                push_req(REQ_BYTE, 8'hFE);
                // TD2 names T=15, so a TCK closes the ATR.
                push_req(REQ_BYTE, 8'h6F);
                push_req(REQ_BYTE, 8'h45);
                push_req(REQ_BYTE, 8'h01);
                push_req(REQ_BYTE, 8'h80);
                push_req(REQ_BYTE, 8'h5A);
                push_req(REQ_BYTE, 8'h3B);
            end else begin
                queued_count = 0;
                while (queued_count < PHASE_ITEMS) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                        repeat ($urandom_range(1, 8))
                            push_req(($urandom_range(0, 7) == 0) ? REQ_RESTART : REQ_BYTE,
                                     8'($urandom_range(0, 255)));
                    else if (sel < 16)
                        queue_atr($urandom_range(15, 18), 1'b1, 1'b0);
                    else if (sel < 26)
                        queue_atr($urandom_range(4, 10), 1'b0, 1'b0);
                    else if (sel < 36)
                        queue_atr($urandom_range(0, 4), 1'b0, 1'b1);
                    else
                        queue_atr($urandom_range(0, 3), 1'b0, 1'b0);
                end
            end
            while (pending_bytes.size() != 0 || req_valid || expected_atr_rsps.size() != 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
src/smcatr_pkg.sv
src/smcatr_step.sv
src/smartcard_atr_parser_unit.sv
sim/tb_smartcard_atr_parser_unit.sv
